/* rtl/core/pfdf_pkg.sv */
package pfdf_pkg;

    // request codes on req_type
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_FILL  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // controller command bytes
    localparam logic [7:0] CMD_PAGE   = 8'hb0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    // configuration port
    localparam int         CFG_ADDR_W        = 3;
    localparam logic       REG_COLUMN_OFFSET = 1'b0;
    localparam logic [6:0] COLUMN_OFFSET_RST = 7'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_FILL,
        KIND_FLUSH
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] page;
        logic [6:0] col;
        logic [7:0] mask;
        logic       pix;
        logic [3:0] flags;
        logic [7:0] fill_even;
        logic [7:0] fill_odd;
    } item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PIX_WR,
        B_FILL,
        B_SCAN,
        B_NONE,
        B_CMD,
        B_DATA_RD,
        B_DATA_LD
    } back_state_t;

endpackage

/* rtl/core/page_framebuffer_dirty_flush.sv */
// channel    handshake               payload
// req        req_valid / req_stall   req_type row col pixel_bit mode_flags fill_even fill_odd
// rsp        rsp_valid / rsp_stall   out_byte is_command none_dirty last
// cfg        apb write/read          column_offset at byte address 0
//
// requests go through a two-entry queue; a pixel write reads, then writes the frame store;
// a fill writes all 2**(page bits + column bits) store bytes in turn; a flush scans 8
// segment marks per cycle, then for the first dirty one sends 3 command bytes, one per
// cycle while not stalled, and 8 data bytes (store read, then output register load)
// rsp_stall holds the output register; the queue keeps taking requests while it has room
// rst_n clears the dirty marks, queue and control; the frame store is not cleared
module page_framebuffer_dirty_flush #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      req_type,
    input  logic [5:0]                      row,
    input  logic [6:0]                      col,
    input  logic                            pixel_bit,
    input  logic [3:0]                      mode_flags,
    input  logic [7:0]                      fill_even,
    input  logic [7:0]                      fill_odd,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [7:0]                      out_byte,
    output logic                            is_command,
    output logic                            none_dirty,
    output logic                            last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pfdf_pkg::*;

    item_t      push_item;
    item_t      head_item;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic [6:0] column_offset_reg;
    logic [6:0] column_offset_next;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_COLUMN_OFFSET);

    always_comb
    begin
        column_offset_next = column_offset_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            column_offset_next = pwdata[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= COLUMN_OFFSET_RST;
        end
        else
        begin
            column_offset_reg <= column_offset_next;
        end
    end

    assign prdata = reg_hit ? {25'd0, column_offset_reg} : 32'd0;

    pfdf_front #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .row        (row),
        .col        (col),
        .pixel_bit  (pixel_bit),
        .mode_flags (mode_flags),
        .fill_even  (fill_even),
        .fill_odd   (fill_odd),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    pfdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    pfdf_back #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (head_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .column_offset (column_offset_reg),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_byte      (out_byte),
        .is_command    (is_command),
        .none_dirty    (none_dirty),
        .last          (last)
    );

endmodule

/* rtl/core/pfdf_front.sv */
module pfdf_front #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic            req_valid,
    output logic            req_stall,
    input  logic [1:0]      req_type,
    input  logic [5:0]      row,
    input  logic [6:0]      col,
    input  logic            pixel_bit,
    input  logic [3:0]      mode_flags,
    input  logic [7:0]      fill_even,
    input  logic [7:0]      fill_odd,
    input  logic            q_full,
    output logic            q_push,
    output pfdf_pkg::item_t q_item
);
    import pfdf_pkg::*;

    logic keep;
    logic in_range;

    assign in_range = (32'(row[5:3]) < PAGES) && (32'(col) < COLUMNS);

    always_comb
    begin
        q_item.page      = row[5:3];
        q_item.col       = col;
        q_item.mask      = 8'b1 << row[2:0];
        q_item.pix       = pixel_bit;
        q_item.flags     = mode_flags;
        q_item.fill_even = fill_even;
        q_item.fill_odd  = fill_odd;
        q_item.kind      = KIND_PIXEL;
        keep             = 1'b0;
        unique case (req_type)
            REQ_PIXEL:
            begin
                q_item.kind = KIND_PIXEL;
                keep        = in_range;
            end
            REQ_FILL:
            begin
                q_item.kind = KIND_FILL;
                keep        = 1'b1;
            end
            REQ_FLUSH:
            begin
                q_item.kind = KIND_FLUSH;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped requests are still accepted, just not queued
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full && keep;

endmodule

/* rtl/core/pfdf_queue.sv */
module pfdf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pfdf_pkg::item_t push_item,
    input  logic            pop,
    output pfdf_pkg::item_t head,
    output logic            full,
    output logic            empty
);
    import pfdf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/pfdf_back.sv */
module pfdf_back #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pfdf_pkg::item_t q_item,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic [6:0]      column_offset,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [7:0]      out_byte,
    output logic            is_command,
    output logic            none_dirty,
    output logic            last
);
    import pfdf_pkg::*;

    localparam int SEGS      = (COLUMNS + 7) / 8;
    localparam int PAGE_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SEG_W     = (SEGS > 1) ? $clog2(SEGS) : 1;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = PAGE_W + COL_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int MARK_W    = PAGE_W + SEG_W;
    localparam int MARKS     = 1 << MARK_W;
    localparam int MARKS_PAD = (MARKS < 8) ? 8 : MARKS;
    localparam int NCHUNK    = MARKS_PAD / 8;
    localparam int CHUNK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FIND_W    = CHUNK_W + 3;

    localparam int FLAG_NORMAL  = 0;
    localparam int FLAG_REVERSE = 1;
    localparam int FLAG_SET     = 2;
    localparam int FLAG_CLR     = 3;

    function automatic logic [7:0] apply_pass(input logic [7:0] v, input logic [7:0] mask,
                                              input logic src, input logic [3:0] flags);
        logic [7:0] r;
        r = v;
        if (flags[FLAG_SET] && src)
        begin
            r = r | mask;
        end
        if (flags[FLAG_CLR] && src)
        begin
            r = r & ~mask;
        end
        return r;
    endfunction

    logic [7:0]         mem [DEPTH];

    back_state_t        state_reg;
    back_state_t        state_next;
    item_t              cur_reg;
    item_t              cur_next;
    logic [7:0]         rd_data_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    logic [ADDR_W-1:0]  sweep_next;
    logic [MARKS_PAD-1:0] dirty_reg;
    logic [MARKS_PAD-1:0] dirty_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CHUNK_W-1:0] chunk_next;
    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  page_next;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEG_W-1:0]   seg_next;
    logic [1:0]         step_reg;
    logic [1:0]         step_next;
    logic [2:0]         dat_reg;
    logic [2:0]         dat_next;
    logic               ob_valid_reg;
    logic               ob_valid_next;
    logic [7:0]         ob_byte_reg;
    logic [7:0]         ob_byte_next;
    logic               ob_cmd_reg;
    logic               ob_cmd_next;
    logic               ob_none_reg;
    logic               ob_none_next;
    logic               ob_last_reg;
    logic               ob_last_next;

    logic [MARKS_PAD-1:0] mark_ok;
    logic [7:0]         chunk_bits;
    logic               hit;
    logic [2:0]         hit_pos;
    logic [FIND_W-1:0]  found;
    logic [MARK_W-1:0]  found_mark;
    logic [SEG_W+2:0]   dcol;
    logic               dcol_ok;
    logic [ADDR_W-1:0]  data_addr;
    logic [ADDR_W-1:0]  head_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic [MARK_W-1:0]  cur_mark;
    logic [7:0]         col_addr;
    logic [7:0]         pix_pass1;
    logic [7:0]         pix_result;
    logic               out_free;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;

    // segments that exist for this geometry
    for (genvar i = 0; i < MARKS_PAD; i++)
    begin : g_mark_ok
        assign mark_ok[i] = ((i >> SEG_W) < PAGES) && ((i % (1 << SEG_W)) < SEGS);
    end

    assign chunk_bits = dirty_reg[{chunk_reg, 3'b000} +: 8];
    assign hit        = |chunk_bits;

    always_comb
    begin
        hit_pos = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (chunk_bits[k])
            begin
                hit_pos = 3'(k);
            end
        end
    end

    assign found      = {chunk_reg, hit_pos};
    assign found_mark = found[MARK_W-1:0];

    assign dcol      = {seg_reg, dat_reg};
    assign dcol_ok   = (32'(dcol) < COLUMNS);
    assign data_addr = {page_reg, COL_W'(dcol)};
    assign head_addr = {PAGE_W'(q_item.page), COL_W'(q_item.col)};
    assign cur_addr  = {PAGE_W'(cur_reg.page), COL_W'(cur_reg.col)};
    assign cur_mark  = {PAGE_W'(cur_reg.page), SEG_W'(cur_reg.col[6:3])};
    assign col_addr  = 8'({seg_reg, 3'b000}) + 8'(column_offset);

    // normal pass then reverse pass
    assign pix_pass1  = cur_reg.flags[FLAG_NORMAL]
                        ? apply_pass(rd_data_reg, cur_reg.mask, cur_reg.pix, cur_reg.flags)
                        : rd_data_reg;
    assign pix_result = cur_reg.flags[FLAG_REVERSE]
                        ? apply_pass(pix_pass1, cur_reg.mask, !cur_reg.pix, cur_reg.flags)
                        : pix_pass1;

    assign out_free = !ob_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        sweep_next    = sweep_reg;
        dirty_next    = dirty_reg;
        chunk_next    = chunk_reg;
        page_next     = page_reg;
        seg_next      = seg_reg;
        step_next     = step_reg;
        dat_next      = dat_reg;
        ob_valid_next = ob_valid_reg && rsp_stall;
        ob_byte_next  = ob_byte_reg;
        ob_cmd_next   = ob_cmd_reg;
        ob_none_next  = ob_none_reg;
        ob_last_next  = ob_last_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = data_addr;
        wr_en         = 1'b0;
        wr_addr       = cur_addr;
        wr_data       = pix_result;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    unique case (q_item.kind)
                        KIND_PIXEL:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_addr;
                            state_next = B_PIX_WR;
                        end
                        KIND_FILL:
                        begin
                            sweep_next = '0;
                            state_next = B_FILL;
                        end
                        KIND_FLUSH:
                        begin
                            chunk_next = '0;
                            state_next = B_SCAN;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end

            B_PIX_WR:
            begin
                wr_en                = 1'b1;
                wr_addr              = cur_addr;
                wr_data              = pix_result;
                dirty_next[cur_mark] = 1'b1;
                state_next           = B_IDLE;
            end

            B_FILL:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = sweep_reg[0] ? cur_reg.fill_odd : cur_reg.fill_even;
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                begin
                    dirty_next = mark_ok;
                    state_next = B_IDLE;
                end
            end

            B_SCAN:
            begin
                if (hit)
                begin
                    page_next         = found_mark[MARK_W-1:SEG_W];
                    seg_next          = found_mark[SEG_W-1:0];
                    dirty_next[found] = 1'b0;
                    step_next         = '0;
                    state_next        = B_CMD;
                end
                else if (chunk_reg == CHUNK_W'(NCHUNK - 1))
                begin
                    state_next = B_NONE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end

            B_NONE:
            begin
                if (out_free)
                begin
                    ob_valid_next = 1'b1;
                    ob_byte_next  = '0;
                    ob_cmd_next   = 1'b0;
                    ob_none_next  = 1'b1;
                    ob_last_next  = 1'b1;
                    state_next    = B_IDLE;
                end
            end

            B_CMD:
            begin
                if (out_free)
                begin
                    ob_valid_next = 1'b1;
                    ob_cmd_next   = 1'b1;
                    ob_none_next  = 1'b0;
                    ob_last_next  = 1'b0;
                    case (step_reg)
                        2'd0:    ob_byte_next = CMD_PAGE + 8'(page_reg);
                        2'd1:    ob_byte_next = CMD_COL_HI + {4'h0, col_addr[7:4]};
                        default: ob_byte_next = {4'h0, col_addr[3:0]};
                    endcase
                    if (step_reg == 2'd2)
                    begin
                        dat_next   = '0;
                        state_next = B_DATA_RD;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            B_DATA_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = data_addr;
                state_next = B_DATA_LD;
            end

            B_DATA_LD:
            begin
                if (out_free)
                begin
                    ob_valid_next = 1'b1;
                    ob_byte_next  = dcol_ok ? rd_data_reg : 8'h00;
                    ob_cmd_next   = 1'b0;
                    ob_none_next  = 1'b0;
                    ob_last_next  = &dat_reg;
                    if (&dat_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        dat_next   = dat_reg + 1'b1;
                        state_next = B_DATA_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            dirty_reg    <= '0;
            sweep_reg    <= '0;
            chunk_reg    <= '0;
            step_reg     <= '0;
            dat_reg      <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dirty_reg    <= dirty_next;
            sweep_reg    <= sweep_next;
            chunk_reg    <= chunk_next;
            step_reg     <= step_next;
            dat_reg      <= dat_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        page_reg    <= page_next;
        seg_reg     <= seg_next;
        ob_byte_reg <= ob_byte_next;
        ob_cmd_reg  <= ob_cmd_next;
        ob_none_reg <= ob_none_next;
        ob_last_reg <= ob_last_next;
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid  = ob_valid_reg;
    assign out_byte   = ob_byte_reg;
    assign is_command = ob_cmd_reg;
    assign none_dirty = ob_none_reg;
    assign last       = ob_last_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pfdf_pkg::*;

    localparam int PAGES         = 8;
    localparam int COLUMNS       = 128;
    localparam int SEGS_PER_PAGE = COLUMNS / 8;
    localparam int SEG_COUNT     = PAGES * SEGS_PER_PAGE;
    localparam int FILL_LATENCY  = PAGES * COLUMNS + 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] ADDR_COLUMN_OFFSET = {REG_COLUMN_OFFSET, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE         = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] row;
        logic [6:0] col;
        logic       pix;
        logic [3:0] flags;
        logic [7:0] fill_even;
        logic [7:0] fill_odd;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       none_dirty;
        logic       last;
    } ctrl_byte_t;

    typedef struct packed {
        req_t       req;
        logic       typed;
        ctrl_byte_t want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            req_type;
    logic [5:0]            row;
    logic [6:0]            col;
    logic                  pixel_bit;
    logic [3:0]            mode_flags;
    logic [7:0]            fill_even;
    logic [7:0]            fill_odd;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [7:0]            out_byte;
    logic                  is_command;
    logic                  none_dirty;
    logic                  last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    page_framebuffer_dirty_flush #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .row        (row),
        .col        (col),
        .pixel_bit  (pixel_bit),
        .mode_flags (mode_flags),
        .fill_even  (fill_even),
        .fill_odd   (fill_odd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .out_byte   (out_byte),
        .is_command (is_command),
        .none_dirty (none_dirty),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // shadow copy of the frame store, dirty marks and column offset
    bit [7:0]           shadow_fb [PAGES][COLUMNS];
    bit [SEG_COUNT-1:0] shadow_dirty;
    bit [6:0]           shadow_col_off;

    ctrl_byte_t bytes_due[$];
    ctrl_byte_t step_bytes[$];
    ctrl_byte_t got_byte;
    ctrl_byte_t want_byte;

    int errors;
    int cycles;
    int hold_left;
    bit hold_req;
    bit quiet;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit [7:0] mode_pass(bit [7:0] v, bit [7:0] mask, bit src, bit [3:0] flags);
        if (flags[2] && src)
            v = v | mask;
        if (flags[3] && src)
            v = v & ~mask;
        return v;
    endfunction

    function automatic void push_byte(bit [7:0] b, bit cmd, bit none, bit fin);
        ctrl_byte_t r;
        r.out_byte   = b;
        r.is_command = cmd;
        r.none_dirty = none;
        r.last       = fin;
        step_bytes.push_back(r);
    endfunction

    function automatic void shadow_apply(req_t it);
        bit [2:0] pg;
        bit [7:0] mask;
        bit [7:0] v;
        bit [7:0] addr;
        int       s;
        int       seg;
        bit       found;
        found = 1'b0;
        case (it.req_type)
            REQ_PIXEL:
            begin
                pg = it.row[5:3];
                mask = 8'd1 << it.row[2:0];
                v = shadow_fb[pg][it.col];
                if (it.flags[0])
                    v = mode_pass(v, mask, it.pix, it.flags);
                if (it.flags[1])
                    v = mode_pass(v, mask, ~it.pix, it.flags);
                shadow_fb[pg][it.col] = v;
                shadow_dirty[pg * SEGS_PER_PAGE + it.col[6:3]] = 1'b1;
            end
            REQ_FILL:
            begin
                for (int p = 0; p < PAGES; p++)
                    for (int c = 0; c < COLUMNS; c++)
                        shadow_fb[p][c] = (c % 2) ? it.fill_odd : it.fill_even;
                shadow_dirty = '1;
            end
            REQ_FLUSH:
            begin
                for (s = 0; s < SEG_COUNT && !found; s++)
                begin
                    if (shadow_dirty[s])
                    begin
                        found = 1'b1;
                        pg = 3'(s / SEGS_PER_PAGE);
                        seg = s % SEGS_PER_PAGE;
                        addr = 8'(seg * 8) + {1'b0, shadow_col_off};
                        push_byte(CMD_PAGE + {5'd0, pg}, 1'b1, 1'b0, 1'b0);
                        push_byte(CMD_COL_HI + {4'd0, addr[7:4]}, 1'b1, 1'b0, 1'b0);
                        push_byte({4'd0, addr[3:0]}, 1'b1, 1'b0, 1'b0);
                        for (int m = 0; m < 8; m++)
                            push_byte(shadow_fb[pg][seg * 8 + m], 1'b0, 1'b0, m == 7);
                        shadow_dirty[s] = 1'b0;
                    end
                end
                if (!found)
                    push_byte(8'd0, 1'b0, 1'b1, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic req_t mk(logic [1:0] t, logic [5:0] r, logic [6:0] c, logic p,
                                logic [3:0] f, logic [7:0] fe, logic [7:0] fo);
        req_t it;
        it.req_type  = t;
        it.row       = r;
        it.col       = c;
        it.pix       = p;
        it.flags     = f;
        it.fill_even = fe;
        it.fill_odd  = fo;
        return it;
    endfunction

    function automatic req_t rand_req(bit allow_fill);
        req_t it;
        int   pick;
        it = req_t'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 50)
            it.req_type = REQ_PIXEL;
        else if (pick < 90)
            it.req_type = REQ_FLUSH;
        else if (pick < 95)
            it.req_type = REQ_UNUSED;
        else
            it.req_type = allow_fill ? REQ_FILL : REQ_PIXEL;
        // pixel writes often land in a few corner segments
        if (it.req_type == REQ_PIXEL && $urandom_range(0, 1))
        begin
            it.row = {($urandom_range(0, 1) ? 3'd7 : 3'd0), 3'($urandom)};
            it.col = {($urandom_range(0, 1) ? 4'd15 : 4'd0), 3'($urandom)};
        end
        return it;
    endfunction

    task automatic send_req(input req_t it, input bit typed, input ctrl_byte_t want);
        int gap;
        req_type   <= it.req_type;
        row        <= it.row;
        col        <= it.col;
        pixel_bit  <= it.pix;
        mode_flags <= it.flags;
        fill_even  <= it.fill_even;
        fill_odd   <= it.fill_odd;
        req_valid  <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        step_bytes.delete();
        shadow_apply(it);
        if (typed)
            bytes_due.push_back(want);
        else
            foreach (step_bytes[i])
                bytes_due.push_back(step_bytes[i]);
        if (!quiet && $urandom_range(0, 99) < 31)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_COLUMN_OFFSET)
            shadow_col_off = data[6:0];
    endtask

    task automatic reg_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_COLUMN_OFFSET;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {25'd0, shadow_col_off})
        begin
            $display("%0t: column_offset read expected %0h got %0h",
                     $time, shadow_col_off, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_offset(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        wait_drained();
        repeat (FILL_LATENCY) @(posedge clk);
        reg_write(addr, data);
        reg_check();
    endtask

    // response side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= !quiet && ($urandom_range(0, 99) < 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            got_byte = {out_byte, is_command, none_dirty, last};
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, got %0h", $time, got_byte);
                errors++;
            end
            else
            begin
                want_byte = bytes_due.pop_front();
                if (got_byte.out_byte !== want_byte.out_byte)
                begin
                    $display("%0t: out_byte expected %0h got %0h",
                             $time, want_byte.out_byte, got_byte.out_byte);
                    errors++;
                end
                if (got_byte.is_command !== want_byte.is_command)
                begin
                    $display("%0t: is_command expected %0b got %0b",
                             $time, want_byte.is_command, got_byte.is_command);
                    errors++;
                end
                if (got_byte.none_dirty !== want_byte.none_dirty)
                begin
                    $display("%0t: none_dirty expected %0b got %0b",
                             $time, want_byte.none_dirty, got_byte.none_dirty);
                    errors++;
                end
                if (got_byte.last !== want_byte.last)
                begin
                    $display("%0t: last expected %0b got %0b",
                             $time, want_byte.last, got_byte.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t   rows[$];
        ctrl_byte_t no_byte;
        ctrl_byte_t none_byte;
        int         n;

        errors         = 0;
        cycles         = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        quiet          = 1'b0;
        shadow_dirty   = '0;
        shadow_col_off = COLUMN_OFFSET_RST;
        no_byte        = '0;
        none_byte      = {8'd0, 1'b0, 1'b1, 1'b1};

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_type   = REQ_PIXEL;
        row        = '0;
        col        = '0;
        pixel_bit  = 1'b0;
        mode_flags = '0;
        fill_even  = '0;
        fill_odd   = '0;
        rsp_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // flush after reset, unused request, then fill so the store is defined, then a flush
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b1, none_byte});
        rows.push_back({mk(REQ_UNUSED, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FILL, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'hff), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        // pixel writes over a range of pass and mode combinations, then flushes, fills and more
        rows.push_back({mk(REQ_PIXEL, 6'd0, 7'd0, 1'b1, 4'b0101, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd63, 7'd127, 1'b1, 4'b1001, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd7, 7'd64, 1'b0, 4'b0110, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd8, 7'd8, 1'b1, 4'b0000, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd9, 7'd9, 1'b1, 4'b1111, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd10, 7'd10, 1'b0, 4'b1111, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd33, 7'd77, 1'b1, 4'b0111, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd34, 7'd78, 1'b0, 4'b1010, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd35, 7'd79, 1'b1, 4'b0011, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FILL, 6'd0, 7'd0, 1'b0, 4'd0, 8'haa, 8'h55), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FILL, 6'd0, 7'd0, 1'b0, 4'd0, 8'hff, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_PIXEL, 6'd62, 7'd126, 1'b0, 4'b1110, 8'h00, 8'h00), 1'b0, no_byte});
        rows.push_back({mk(REQ_FLUSH, 6'd63, 7'd127, 1'b1, 4'hf, 8'hff, 8'hff), 1'b0, no_byte});
        rows.push_back({mk(REQ_UNUSED, 6'd63, 7'd127, 1'b1, 4'hf, 8'hff, 8'hff), 1'b0, no_byte});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_check();

        foreach (rows[i])
            send_req(rows[i].req, rows[i].typed, rows[i].want);

        // largest offset, long receiver hold-off while the queue fills
        set_offset(ADDR_COLUMN_OFFSET, 32'd127);
        set_offset(ADDR_SPARE, $urandom);
        for (int i = 0; i < 20; i++)
            send_req(rand_req(1'b1), 1'b0, no_byte);
        hold_req = 1'b1;
        n = 0;
        while (shadow_dirty != '0 && n < 200)
        begin
            send_req(mk(REQ_FLUSH, 6'($urandom), 7'($urandom), 1'($urandom), 4'($urandom),
                        8'($urandom), 8'($urandom)), 1'b0, no_byte);
            n++;
        end
        send_req(mk(REQ_FLUSH, 6'd0, 7'd0, 1'b0, 4'd0, 8'h00, 8'h00), 1'b0, no_byte);

        // smallest offset, sender pauses halfway until everything has come back
        set_offset(ADDR_COLUMN_OFFSET, 32'd0);
        for (int i = 0; i < 20; i++)
        begin
            if (i == 10)
                wait_drained();
            send_req(rand_req(1'b0), 1'b0, no_byte);
        end

        // random offset with junk in the upper bits, no idling on either side
        set_offset(ADDR_COLUMN_OFFSET, {$urandom_range(0, 1) ? 25'h1ffffff : 25'($urandom),
                                        7'($urandom)});
        quiet = 1'b1;
        for (int i = 0; i < 20; i++)
            send_req(rand_req(1'b0), 1'b0, no_byte);
        quiet = 1'b0;

        set_offset(ADDR_COLUMN_OFFSET, {25'd0, COLUMN_OFFSET_RST});
        for (int i = 0; i < 20; i++)
            send_req(rand_req(i == 10), 1'b0, no_byte);

        wait_drained();
        repeat (FILL_LATENCY) @(posedge clk);
        if (errors == 0 && bytes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/pfdf_pkg.sv
rtl/core/pfdf_front.sv
rtl/core/pfdf_queue.sv
rtl/core/pfdf_back.sv
rtl/core/page_framebuffer_dirty_flush.sv
tb/tb_top.sv
